[hdl/pngsp_pkg.sv]
// ----------------------------------------------------------------------------
// pngsp_pkg
// Shared types, constants and lookup functions for the PNG stream splitter.
// ----------------------------------------------------------------------------
package pngsp_pkg;

   // width of stream offsets; offsets and sizes wrap at this width
   localparam int OFFSET_BITS = 32;
   localparam int OUT_BITS    = 32;
   localparam int SKIP_BITS   = 33;

   localparam logic [7:0] SIG_FIRST = 8'h89;
   localparam logic [7:0] SIG_EOF   = 8'h1a;

   typedef enum logic [1:0] {
      PH_SIG,
      PH_LEN,
      PH_TYPE,
      PH_SKIP
   } phase_type;

   typedef enum logic [1:0] {
      ST_DONE   = 2'd0,
      ST_BADSIG = 2'd1,
      ST_TRUNC  = 2'd2
   } status_type;

   typedef struct packed {
      logic                valid;
      logic [OUT_BITS-1:0] frame_offset;
      logic [OUT_BITS-1:0] frame_size;
      status_type          status;
   } result_type;

   // eight-byte png signature
   function automatic logic [7:0] sig_byte(input logic [2:0] idx);
      logic [7:0] b;
      case (idx)
         3'd0:    b = SIG_FIRST;
         3'd1:    b = 8'h50;
         3'd2:    b = 8'h4e;
         3'd3:    b = 8'h47;
         3'd4:    b = 8'h0d;
         3'd5:    b = 8'h0a;
         3'd6:    b = SIG_EOF;
         3'd7:    b = 8'h0a;
         default: b = SIG_FIRST;
      endcase
      return b;
   endfunction

   // chunk type "IEND"
   function automatic logic [7:0] end_type_byte(input logic [1:0] idx);
      logic [7:0] b;
      case (idx)
         2'd0:    b = 8'h49;
         2'd1:    b = 8'h45;
         2'd2:    b = 8'h4e;
         2'd3:    b = 8'h44;
         default: b = 8'h49;
      endcase
      return b;
   endfunction

   // low bits of an offset for the result fields
   function automatic logic [OUT_BITS-1:0] to_out(input logic [OFFSET_BITS-1:0] v);
      logic [63:0] w;
      w = 64'(v);
      return w[OUT_BITS-1:0];
   endfunction

endpackage

[hdl/pngsp_if.sv]
// ----------------------------------------------------------------------------
// pngsp_if
// Stream channels of the PNG stream splitter: byte words in, frame words out.
// ----------------------------------------------------------------------------
interface pngsp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface pngsp_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] frame_offset;
   logic [31:0] frame_size;
   logic [1:0]  status;

   modport source (output valid, output frame_offset, output frame_size, output status,
                   input ready);
   modport sink   (input valid, input frame_offset, input frame_size, input status,
                   output ready);
endinterface

[hdl/pngsp_core.sv]
// ----------------------------------------------------------------------------
// pngsp_core
// Chunk walker: parse state, one byte word per process strobe, and the result
// that the byte causes.
// ----------------------------------------------------------------------------
module pngsp_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  process,
   input  logic [7:0]            data_byte,
   input  logic                  last_byte,
   output pngsp_pkg::result_type result,
   output logic                  halted
);
   import pngsp_pkg::*;

   phase_type                   phase_ff, phase_in;
   logic [2:0]                  count_ff, count_in;
   logic [31:0]                 length_ff, length_in;
   logic [SKIP_BITS-1:0]        skip_ff, skip_in;
   logic                        is_end_ff, is_end_in;
   logic [OFFSET_BITS-1:0]      pos_ff, pos_in;
   logic [OFFSET_BITS-1:0]      start_ff, start_in;
   logic                        halted_ff, halted_in;

   logic                        sig_bad;
   logic                        frame_done;
   logic                        trunc;
   logic [SKIP_BITS-1:0]        skip_dec;
   logic                        type_match;
   logic [OFFSET_BITS-1:0]      size;

   // shared decisions
   always_comb begin
      sig_bad    = (phase_ff == PH_SIG) && (data_byte != sig_byte(count_ff));
      type_match = data_byte == end_type_byte(count_ff[1:0]);
      skip_dec   = (skip_ff != '0) ? skip_ff - SKIP_BITS'(1) : skip_ff;
      frame_done = (phase_ff == PH_SKIP) && (skip_dec == '0) && is_end_ff;
   end

   // next state
   always_comb begin
      phase_in  = phase_ff;
      count_in  = count_ff;
      length_in = length_ff;
      skip_in   = skip_ff;
      is_end_in = is_end_ff;
      pos_in    = pos_ff;
      start_in  = start_ff;
      halted_in = halted_ff;
      trunc     = 1'b0;
      if (process && !halted_ff) begin
         case (phase_ff)
            PH_SIG: begin
               if (count_ff == 3'd0) begin
                  start_in = pos_ff;
               end
               count_in = count_ff + 3'd1;
               if (count_ff == 3'd7) begin
                  length_in = '0;
                  phase_in  = PH_LEN;
               end
            end
            PH_LEN: begin
               length_in = {length_ff[23:0], data_byte};
               count_in  = count_ff + 3'd1;
               if (count_ff == 3'd3) begin
                  count_in = '0;
                  phase_in = PH_TYPE;
               end
            end
            PH_TYPE: begin
               is_end_in = (count_ff == 3'd0) ? type_match : (is_end_ff && type_match);
               count_in  = count_ff + 3'd1;
               if (count_ff == 3'd3) begin
                  count_in = '0;
                  skip_in  = SKIP_BITS'(length_ff) + SKIP_BITS'(4);
                  phase_in = PH_SKIP;
               end
            end
            PH_SKIP: begin
               skip_in = skip_dec;
               if (skip_dec == '0) begin
                  length_in = '0;
                  count_in  = '0;
                  is_end_in = 1'b0;
                  phase_in  = is_end_ff ? PH_SIG : PH_LEN;
               end
            end
            default: begin
               phase_in = PH_SIG;
            end
         endcase
         pos_in = pos_ff + OFFSET_BITS'(1);
         if (sig_bad) begin
            // halt until reset; phase, count and position stay where they are
            halted_in = 1'b1;
            phase_in  = phase_ff;
            count_in  = count_ff;
            pos_in    = pos_ff;
         end else if (last_byte) begin
            trunc     = !frame_done && !(phase_in == PH_SIG && count_in == 3'd0);
            phase_in  = PH_SIG;
            count_in  = '0;
            length_in = '0;
            skip_in   = '0;
            is_end_in = 1'b0;
            pos_in    = '0;
         end
      end
   end

   // result for the byte in process
   always_comb begin
      logic [OFFSET_BITS-1:0] start_now;
      start_now = (phase_ff == PH_SIG && count_ff == 3'd0) ? pos_ff : start_ff;
      size      = pos_ff + OFFSET_BITS'(1) - start_now;
      result.valid        = process && !halted_ff && (sig_bad || frame_done || trunc);
      result.frame_offset = to_out(start_now);
      result.frame_size   = to_out(size);
      if (sig_bad) begin
         result.status = ST_BADSIG;
      end else if (frame_done) begin
         result.status = ST_DONE;
      end else begin
         result.status = ST_TRUNC;
      end
   end

   // the fresh stream after a final byte also clears the start offset
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_SIG;
         count_ff  <= '0;
         length_ff <= '0;
         skip_ff   <= '0;
         is_end_ff <= 1'b0;
         pos_ff    <= '0;
         start_ff  <= '0;
         halted_ff <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         count_ff  <= count_in;
         length_ff <= length_in;
         skip_ff   <= skip_in;
         is_end_ff <= is_end_in;
         pos_ff    <= pos_in;
         start_ff  <= (process && !halted_ff && !sig_bad && last_byte) ? '0 : start_in;
         halted_ff <= halted_in;
      end
   end

   assign halted = halted_ff;

endmodule

[hdl/png_stream_frame_splitter.sv]
// ----------------------------------------------------------------------------
// png_stream_frame_splitter
// Splits a byte stream of concatenated PNG images and reports the offset and
// size of each image, a bad signature or a stream that ends mid-image.
// ----------------------------------------------------------------------------
//  channel  dir  payload                              accepted when
//  req_ch   in   data_byte[7:0], last_byte            valid && ready
//  rsp_ch   out  frame_offset, frame_size, status     valid && ready
//
//  one byte word per clock while results drain: a word is held in an input
//  register, walked by the chunk parser once the output register is free or
//  being read, and its result lands in the output register as it is walked.
//  a stalled result only holds the input register; a new word is taken
//  whenever the input register is empty or moves on in that cycle.
//  synchronous reset clears the parse state and both valid flags.
// ----------------------------------------------------------------------------
module png_stream_frame_splitter (
   input  logic clock,
   input  logic reset,
   pngsp_req_if.sink   req_ch,
   pngsp_rsp_if.source rsp_ch
);
   import pngsp_pkg::*;

   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;
   logic       advance;
   result_type result;
   logic       halted;
   logic       out_valid_ff;
   result_type out_ff;

   assign advance      = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         in_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         in_byte_ff <= req_ch.data_byte;
         in_last_ff <= req_ch.last_byte;
      end
   end

   pngsp_core u_core (
      .clock     (clock),
      .reset     (reset),
      .process   (advance),
      .data_byte (in_byte_ff),
      .last_byte (in_last_ff),
      .result    (result),
      .halted    (halted)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (result.valid) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (result.valid) begin
         out_ff <= result;
      end
   end

   assign rsp_ch.valid        = out_valid_ff;
   assign rsp_ch.frame_offset = out_ff.frame_offset;
   assign rsp_ch.frame_size   = out_ff.frame_size;
   assign rsp_ch.status       = out_ff.status;

`ifndef SYNTHESIS
   // once halted, only reset clears it
   a_halt_sticks: assert property (@(posedge clock) disable iff (reset)
      halted |=> halted)
      else $error("halt flag dropped without reset");

   // a bad signature word is only shown once the parser has halted
   a_badsig_halts: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.status == ST_BADSIG) |-> halted)
      else $error("bad signature reported while not halted");

   // a new result never overwrites one still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_ch.ready) |-> !result.valid)
      else $error("result register overwritten while stalled");

   // an empty input register always takes a word
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> req_ch.ready)
      else $error("input not ready while input register empty");
`endif

endmodule

[sim/tb_png_stream_frame_splitter.sv]
// ----------------------------------------------------------------------------
// tb_png_stream_frame_splitter
// Drives byte words of concatenated PNG images into the splitter and checks
// every frame word against an in-bench parser of the same stream. Stimulus:
// a few directed images, then random images (whole, closing the stream, cut
// short, or with huge chunk lengths), and a bad signature that halts the block.
// ----------------------------------------------------------------------------
module tb_png_stream_frame_splitter;
   timeunit 1ns;
   timeprecision 1ps;

   import pngsp_pkg::*;

   localparam logic [63:0] PNG_SIGNATURE = {SIG_FIRST, 8'h50, 8'h4e, 8'h47,
                                            8'h0d, 8'h0a, SIG_EOF, 8'h0a};
   localparam logic [31:0] IEND_TYPE = "IEND";

   typedef struct {
      logic [7:0] data;
      logic       last;
      bit         hold;
   } stim_word_type;

   typedef struct {
      logic [31:0] frame_offset;
      logic [31:0] frame_size;
      status_type  status;
   } frame_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   pngsp_req_if req_ch ();
   pngsp_rsp_if rsp_ch ();

   png_stream_frame_splitter i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   stim_word_type  byte_plan[$];
   frame_word_type frames_due[$];
   logic [7:0]     img_bytes[$];
   int unsigned    errors = 0;
   int unsigned    cyc = 0;
   logic           calm;

   // no random idling on either side inside this window
   assign calm = (cyc >= 600) && (cyc < 1100);

   always @(posedge clock) cyc <= cyc + 1;

   // ---------------------------------------------------------------- parser
   phase_type   parse_phase = PH_SIG;
   int unsigned field_cnt = 0;
   logic [31:0] len_acc = '0;
   logic [32:0] skip_left = '0;
   logic        end_type_match = 1'b0;
   logic [31:0] stream_pos = '0;
   logic [31:0] frame_start = '0;
   logic        halted = 1'b0;

   function automatic frame_word_type make_word(input logic [31:0] pos, input status_type st);
      frame_word_type w;
      w.frame_offset = frame_start;
      w.frame_size   = pos + 32'd1 - frame_start;
      w.status       = st;
      return w;
   endfunction

   function automatic bit parse_byte(input logic [7:0] b, input logic last,
                                     output frame_word_type w);
      logic [31:0] pos;
      bit          hit;
      bit          match;
      pos = stream_pos;
      hit = 1'b0;
      w   = make_word(pos, ST_DONE);
      if (halted) return 1'b0;
      case (parse_phase)
         PH_SIG: begin
            if (field_cnt == 0) frame_start = pos;
            if (b != PNG_SIGNATURE[63-8*field_cnt -: 8]) begin
               w = make_word(pos, ST_BADSIG);
               halted = 1'b1;
               return 1'b1;
            end
            field_cnt++;
            if (field_cnt >= 8) begin
               field_cnt = 0;
               len_acc = '0;
               parse_phase = PH_LEN;
            end
         end
         PH_LEN: begin
            len_acc = {len_acc[23:0], b};
            field_cnt++;
            if (field_cnt >= 4) begin
               field_cnt = 0;
               parse_phase = PH_TYPE;
            end
         end
         PH_TYPE: begin
            match = (b == IEND_TYPE[31-8*field_cnt -: 8]);
            end_type_match = (field_cnt == 0) ? match : (end_type_match && match);
            field_cnt++;
            if (field_cnt >= 4) begin
               field_cnt = 0;
               skip_left = {1'b0, len_acc} + 33'd4;
               parse_phase = PH_SKIP;
            end
         end
         default: begin
            if (skip_left != 0) skip_left--;
            if (skip_left == 0) begin
               len_acc = '0;
               field_cnt = 0;
               if (end_type_match) begin
                  w = make_word(pos, ST_DONE);
                  hit = 1'b1;
                  parse_phase = PH_SIG;
               end else begin
                  parse_phase = PH_LEN;
               end
               end_type_match = 1'b0;
            end
         end
      endcase
      stream_pos = pos + 32'd1;
      if (last) begin
         if (!hit && !(parse_phase == PH_SIG && field_cnt == 0)) begin
            w = make_word(pos, ST_TRUNC);
            hit = 1'b1;
         end
         // the next word opens a new stream at offset zero
         parse_phase = PH_SIG;
         field_cnt = 0;
         len_acc = '0;
         skip_left = '0;
         end_type_match = 1'b0;
         stream_pos = '0;
         frame_start = '0;
      end
      return hit;
   endfunction

   // ------------------------------------------------------------- stimulus
   function automatic void push_byte(input logic [7:0] b, input logic last = 1'b0,
                                     input bit hold = 1'b0);
      stim_word_type s;
      s.data = b;
      s.last = last;
      s.hold = hold;
      byte_plan.push_back(s);
   endfunction

   function automatic void put_signature();
      for (int i = 0; i < 8; i++) img_bytes.push_back(PNG_SIGNATURE[63-8*i -: 8]);
   endfunction

   function automatic void put_header(input logic [31:0] len, input logic [31:0] kind);
      for (int i = 0; i < 4; i++) img_bytes.push_back(len[31-8*i -: 8]);
      for (int i = 0; i < 4; i++) img_bytes.push_back(kind[31-8*i -: 8]);
   endfunction

   function automatic void put_chunk(input logic [31:0] len, input logic [31:0] kind);
      put_header(len, kind);
      repeat (len + 4) img_bytes.push_back(8'($urandom_range(255)));
   endfunction

   function automatic logic [31:0] pick_len();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 70) return $urandom_range(8);
      else if (r < 95) return $urandom_range(40, 9);
      else return $urandom_range(600, 100);
   endfunction

   // any chunk type but IEND; near misses exercise the type compare
   function automatic logic [31:0] pick_kind();
      logic [31:0] kind;
      int unsigned k;
      case ($urandom_range(3))
         0: kind = $urandom;
         1: begin
            kind = IEND_TYPE;
            k = $urandom_range(3);
            kind[31-8*k -: 8] = kind[31-8*k -: 8] ^ 8'($urandom_range(255, 1));
         end
         2: for (int i = 0; i < 4; i++)
               kind[31-8*i -: 8] = 8'($urandom_range(25)) + ($urandom_range(1) ? 8'h41 : 8'h61);
         default: kind = {IEND_TYPE[31:8], 8'($urandom_range(255))};
      endcase
      if (kind == IEND_TYPE) kind[0] = ~kind[0];
      return kind;
   endfunction

   function automatic void build_image(input int unsigned n_chunks, input logic [31:0] end_len);
      img_bytes.delete();
      put_signature();
      repeat (n_chunks) put_chunk(pick_len(), pick_kind());
      put_chunk(end_len, IEND_TYPE);
   endfunction

   // cut < 0 sends the whole image with no end-of-stream mark
   function automatic void emit_image(input int cut, input bit hold);
      for (int i = 0; i < img_bytes.size(); i++) begin
         push_byte(img_bytes[i], i == cut, hold && i == 0);
         if (i == cut) break;
      end
   endfunction

   initial begin
      int unsigned r;
      int unsigned k;
      int unsigned next_hold_at;
      bit          hold;

      req_ch.valid     = 1'b0;
      req_ch.data_byte = '0;
      req_ch.last_byte = 1'b0;
      rsp_ch.ready     = 1'b0;

      // smallest image, closing the stream on its last crc byte
      img_bytes.delete();
      put_signature();
      put_header(32'd0, IEND_TYPE);
      img_bytes.push_back(8'h00);
      img_bytes.push_back(8'hff);
      img_bytes.push_back(8'h00);
      img_bytes.push_back(8'hff);
      emit_image(img_bytes.size() - 1, 1'b0);
      // stream ends right after a new image opens
      push_byte(SIG_FIRST, 1'b1);

      next_hold_at = 500;
      while (byte_plan.size() < 1800) begin
         hold = byte_plan.size() >= next_hold_at;
         if (hold) next_hold_at += 600;
         r = $urandom_range(99);
         build_image($urandom_range(3), ($urandom_range(9) == 0) ? $urandom_range(6) : 0);
         if (r < 70) begin
            emit_image(-1, hold);
         end else if (r < 80) begin
            emit_image(img_bytes.size() - 1, hold);
         end else if (r < 93) begin
            emit_image($urandom_range(img_bytes.size() - 2), hold);
         end else begin
            // huge chunk length, stream ends inside the header or data
            img_bytes.delete();
            put_signature();
            put_header($urandom | 32'h0001_0000, $urandom_range(1) ? pick_kind() : IEND_TYPE);
            repeat ($urandom_range(10, 1)) img_bytes.push_back(8'($urandom_range(255)));
            emit_image($urandom_range(img_bytes.size() - 1, 8), hold);
         end
      end

      // bad signature last: the block halts and ignores everything after it
      k = $urandom_range(7);
      for (int i = 0; i < k; i++) push_byte(PNG_SIGNATURE[63-8*i -: 8]);
      push_byte(PNG_SIGNATURE[63-8*k -: 8] ^ 8'($urandom_range(255, 1)));
      repeat (12) push_byte(8'($urandom_range(255)), $urandom_range(3) == 0);

      while (byte_plan.size() != 0 || req_ch.valid) @(posedge clock);
      while (frames_due.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin
      #2ms;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // ---------------------------------------------------------------- driver
   always @(posedge clock) begin
      frame_word_type w;
      bit             gap;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            if (parse_byte(req_ch.data_byte, req_ch.last_byte, w)) frames_due.push_back(w);
            void'(byte_plan.pop_front());
         end
         if (!req_ch.valid || req_ch.ready) begin
            gap = !calm && ($urandom_range(99) < 9);
            // hold the word back until every frame word in flight has come out
            if (byte_plan.size() != 0 && byte_plan[0].hold && frames_due.size() != 0)
               gap = 1'b1;
            if (byte_plan.size() == 0 || gap) begin
               req_ch.valid <= 1'b0;
            end else begin
               req_ch.valid     <= 1'b1;
               req_ch.data_byte <= byte_plan[0].data;
               req_ch.last_byte <= byte_plan[0].last;
            end
         end
      end
   end

   // --------------------------------------------------------------- monitor
   always @(posedge clock) begin
      frame_word_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (frames_due.size() == 0) begin
               $error("unexpected frame word: offset %0d, size %0d, status %0d",
                      rsp_ch.frame_offset, rsp_ch.frame_size, rsp_ch.status);
               errors++;
            end else begin
               want = frames_due.pop_front();
               if (rsp_ch.frame_offset !== want.frame_offset) begin
                  $error("frame_offset mismatch: expected %0d, actual %0d",
                         want.frame_offset, rsp_ch.frame_offset);
                  errors++;
               end
               if (rsp_ch.frame_size !== want.frame_size) begin
                  $error("frame_size mismatch: expected %0d, actual %0d",
                         want.frame_size, rsp_ch.frame_size);
                  errors++;
               end
               if (rsp_ch.status !== 2'(want.status)) begin
                  $error("status mismatch: expected %0d, actual %0d",
                         want.status, rsp_ch.status);
                  errors++;
               end
            end
         end
         rsp_ch.ready <= calm || ($urandom_range(99) >= 9);
      end
   end

endmodule
